FILE: rtl/core/jtc_pkg.sv
// Types and codes shared by the journal transaction controller.
`timescale 1ns / 1ps
`default_nettype none

package jtc_pkg;

  localparam int BLOCK_W  = 20;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 3;
  localparam int ACTION_W = 3;
  localparam int CMD_W    = 2;
  localparam int NEED_W   = 12;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN = 2'd0,
    CMD_END   = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NONE  = 2'd3
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_BEGUN      = 3'd0,
    ST_WAIT_SPACE = 3'd1,
    ST_ENDED      = 3'd2,
    ST_ADDED      = 3'd3,
    ST_ABSORBED   = 3'd4,
    ST_TABLE_FULL = 3'd5,
    ST_COMMIT     = 3'd6,
    ST_NO_BEGIN   = 3'd7
  } status_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE    = 3'd0,
    ACT_COPY    = 3'd1,
    ACT_HEADER  = 3'd2,
    ACT_INSTALL = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_SEARCH,
    SQ_COPY,
    SQ_HEADER,
    SQ_INSTALL,
    SQ_CLEAR
  } seq_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [BLOCK_W-1:0] block_number;
  } req_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ACTION_W-1:0] action;
    logic [BLOCK_W-1:0]  source_block;
    logic [BLOCK_W-1:0]  dest_block;
    logic [COUNT_W-1:0]  header_count;
    logic                last;
  } rsp_word_t;

  localparam int CFG_LOG_START = 0;

endpackage

`default_nettype wire

FILE: rtl/core/journal_transaction_controller_top.sv
// Journal transaction controller: log table, operation count and commit sequencer.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+----------------------------------
//  req     | in        | req_valid/req_stall  | command, block_number
//  rsp     | out       | rsp_valid/rsp_stall  | status, action, blocks, count, last
//  apb     | in        | psel/penable/pready  | log_start_block at address 0
//
// A write searches the table: a single-port memory read one entry a cycle while
// a single comparator checks it. A commit of n entries emits 2n+2 words.
// Reset (rst, synchronous) empties the table and clears the operation count.
// A stalled rsp holds the sequencer; req stalls until the item is finished.
`timescale 1ns / 1ps
`default_nettype none

module journal_transaction_controller_top
  import jtc_pkg::*;
#(
  parameter int LOG_ENTRIES = 30,
  parameter int OP_RESERVE  = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire req_word_t   req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_word_t        rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int IW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;

  // configuration
  logic [BLOCK_W-1:0] log_start_block;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-BLOCK_W){1'b0}}, log_start_block} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_start_block <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'(CFG_LOG_START))) begin
      log_start_block <= pwdata[BLOCK_W-1:0];
    end
  end

  // sequencer state
  seq_state_t         state, state_next;
  logic [COUNT_W-1:0] entry_count, entry_count_next;
  logic [COUNT_W-1:0] open_ops, open_ops_next;
  logic [COUNT_W-1:0] rd_idx, rd_idx_next;
  logic               cmp_valid, cmp_valid_next;
  logic [CMD_W-1:0]   cmd;
  logic [BLOCK_W-1:0] blk;

  // log table
  logic [BLOCK_W-1:0] table_mem [LOG_ENTRIES];
  logic [BLOCK_W-1:0] rd_data;
  logic               rd_en;
  logic               mem_we;

  logic               emit;
  rsp_word_t          res;
  logic               slot_free;
  logic               accept;
  logic [NEED_W-1:0]  need;
  logic [COUNT_W:0]   open_plus;
  logic               hit;
  logic [BLOCK_W-1:0] slot_block;

  assign req_stall = (state != SQ_IDLE);
  assign accept    = req_valid && !req_stall;
  assign slot_free = !rsp_valid || !rsp_stall;

  assign open_plus  = {1'b0, open_ops} + 1'b1;
  assign need       = NEED_W'(entry_count) + NEED_W'(open_plus) * NEED_W'(OP_RESERVE);
  assign hit        = cmp_valid && (rd_data == blk);
  // read data belongs to entry rd_idx-1, whose slot is log_start_block + rd_idx
  assign slot_block = log_start_block + BLOCK_W'(rd_idx);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[entry_count[IW-1:0]] <= blk;
    end
    if (rd_en) begin
      rd_data <= table_mem[rd_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      open_ops    <= '0;
      rd_idx      <= '0;
      cmp_valid   <= 1'b0;
    end else begin
      entry_count <= entry_count_next;
      open_ops    <= open_ops_next;
      rd_idx      <= rd_idx_next;
      cmp_valid   <= cmp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= req.command;
      blk <= req.block_number;
    end
  end

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    open_ops_next    = open_ops;
    rd_idx_next      = rd_idx;
    cmp_valid_next   = cmp_valid;
    rd_en            = 1'b0;
    mem_we           = 1'b0;
    emit             = 1'b0;
    res              = '0;
    res.status       = ST_BEGUN;
    res.action       = ACT_NONE;
    res.header_count = entry_count;
    res.last         = 1'b1;

    case (state)
      SQ_IDLE: begin
        if (accept) begin
          rd_idx_next    = '0;
          cmp_valid_next = 1'b0;
          case (req.command)
            CMD_BEGIN: state_next = SQ_EXEC;
            CMD_END:   state_next = SQ_EXEC;
            CMD_WRITE: state_next = SQ_SEARCH;
            default:   state_next = SQ_IDLE;
          endcase
        end
      end

      SQ_EXEC: begin
        if (cmd == CMD_BEGIN) begin
          if (slot_free) begin
            emit       = 1'b1;
            state_next = SQ_IDLE;
            if (need > NEED_W'(LOG_ENTRIES)) begin
              res.status = ST_WAIT_SPACE;
            end else begin
              res.status    = ST_BEGUN;
              open_ops_next = open_plus[COUNT_W-1:0];
            end
          end
        end else if (open_ops == '0) begin
          if (slot_free) begin
            emit       = 1'b1;
            res.status = ST_NO_BEGIN;
            state_next = SQ_IDLE;
          end
        end else if (open_ops == COUNT_W'(1) && entry_count != '0) begin
          // last operation closes with logged blocks: start the commit
          open_ops_next = '0;
          state_next    = SQ_COPY;
        end else if (slot_free) begin
          emit          = 1'b1;
          res.status    = ST_ENDED;
          open_ops_next = open_ops - 1'b1;
          state_next    = SQ_IDLE;
        end
      end

      SQ_SEARCH: begin
        if (hit) begin
          if (slot_free) begin
            emit           = 1'b1;
            res.status     = ST_ABSORBED;
            cmp_valid_next = 1'b0;
            state_next     = SQ_IDLE;
          end
        end else if (rd_idx == entry_count) begin
          if (slot_free) begin
            emit           = 1'b1;
            cmp_valid_next = 1'b0;
            state_next     = SQ_IDLE;
            if (entry_count >= COUNT_W'(LOG_ENTRIES)) begin
              res.status = ST_TABLE_FULL;
            end else begin
              mem_we           = 1'b1;
              entry_count_next = entry_count + 1'b1;
              res.status       = ST_ADDED;
              res.header_count = entry_count + 1'b1;
            end
          end
        end else begin
          rd_en          = 1'b1;
          rd_idx_next    = rd_idx + 1'b1;
          cmp_valid_next = 1'b1;
        end
      end

      SQ_COPY, SQ_INSTALL: begin
        if (cmp_valid) begin
          if (slot_free) begin
            emit       = 1'b1;
            res.status = ST_COMMIT;
            res.last   = 1'b0;
            if (state == SQ_COPY) begin
              res.action       = ACT_COPY;
              res.source_block = rd_data;
              res.dest_block   = slot_block;
            end else begin
              res.action       = ACT_INSTALL;
              res.source_block = slot_block;
              res.dest_block   = rd_data;
            end
            if (rd_idx < entry_count) begin
              rd_en       = 1'b1;
              rd_idx_next = rd_idx + 1'b1;
            end else begin
              cmp_valid_next = 1'b0;
              rd_idx_next    = '0;
              state_next     = (state == SQ_COPY) ? SQ_HEADER : SQ_CLEAR;
            end
          end
        end else begin
          rd_en          = 1'b1;
          rd_idx_next    = rd_idx + 1'b1;
          cmp_valid_next = 1'b1;
        end
      end

      SQ_HEADER: begin
        if (slot_free) begin
          emit           = 1'b1;
          res.status     = ST_COMMIT;
          res.action     = ACT_HEADER;
          res.dest_block = log_start_block;
          res.last       = 1'b0;
          state_next     = SQ_INSTALL;
        end
      end

      SQ_CLEAR: begin
        if (slot_free) begin
          emit             = 1'b1;
          res.status       = ST_COMMIT;
          res.action       = ACT_CLEAR;
          res.dest_block   = log_start_block;
          res.header_count = '0;
          entry_count_next = '0;
          state_next       = SQ_IDLE;
        end
      end

      default: begin
        state_next = SQ_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

FILE: sim/journal_transaction_controller_tb.sv
// Self-checking testbench for the journal transaction controller: directed, fill and random traffic.
`timescale 1ns / 1ps

module testbench;
  import jtc_pkg::*;

  localparam int LOG_ENTRIES  = 30;
  localparam int OP_RESERVE   = 10;
  localparam int DRAIN_CYCLES = LOG_ENTRIES + 16;
  localparam int CYCLE_LIMIT  = 600000;
  localparam logic [2:0] LOG_START_ADDR = 3'(4 * CFG_LOG_START);
  localparam logic [BLOCK_W-1:0] BLOCK_MAX = '1;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_word_t   req       = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_word_t   rsp;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state
  logic [BLOCK_W-1:0] log_base = '0;
  logic [BLOCK_W-1:0] journal [LOG_ENTRIES];
  logic [COUNT_W-1:0] entry_count = '0;
  logic [COUNT_W-1:0] open_ops = '0;
  rsp_word_t pending_responses [$];

  bit idling        = 1'b0;
  int stall_left    = 0;
  int cycle_count   = 0;
  int mismatches    = 0;
  int items_sent    = 0;
  int words_checked = 0;
  int commits_seen  = 0;
  int cfg_writes    = 0;

  journal_transaction_controller_top #(
    .LOG_ENTRIES(LOG_ENTRIES),
    .OP_RESERVE (OP_RESERVE)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  function automatic rsp_word_t status_word(input status_t st);
    rsp_word_t r;
    r = '0;
    r.status = st;
    r.header_count = entry_count;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic rsp_word_t commit_word(input action_t act, input logic [BLOCK_W-1:0] src,
                                            input logic [BLOCK_W-1:0] dst,
                                            input logic [COUNT_W-1:0] cnt);
    rsp_word_t r;
    r = '0;
    r.status = ST_COMMIT;
    r.action = act;
    r.source_block = src;
    r.dest_block = dst;
    r.header_count = cnt;
    return r;
  endfunction

  // Works out the response words for one accepted request word
  function automatic void predict_journal(input req_word_t w);
    int need;
    bit hit;
    logic [BLOCK_W-1:0] slot;
    rsp_word_t r;
    case (w.command)
      CMD_BEGIN: begin
        need = int'(entry_count) + (int'(open_ops) + 1) * OP_RESERVE;
        if (need > LOG_ENTRIES) begin
          pending_responses.push_back(status_word(ST_WAIT_SPACE));
        end else begin
          open_ops = open_ops + 1'b1;
          pending_responses.push_back(status_word(ST_BEGUN));
        end
      end
      CMD_END: begin
        if (open_ops == 0) begin
          pending_responses.push_back(status_word(ST_NO_BEGIN));
        end else begin
          open_ops = open_ops - 1'b1;
          if (open_ops == 0 && entry_count != 0) begin
            // group commit: copies, header, installs, clear
            for (int i = 0; i < int'(entry_count); i++) begin
              slot = log_base + BLOCK_W'(i + 1);
              pending_responses.push_back(commit_word(ACT_COPY, journal[COUNT_W'(i)], slot,
                                                      entry_count));
            end
            pending_responses.push_back(commit_word(ACT_HEADER, '0, log_base, entry_count));
            for (int i = 0; i < int'(entry_count); i++) begin
              slot = log_base + BLOCK_W'(i + 1);
              pending_responses.push_back(commit_word(ACT_INSTALL, slot, journal[COUNT_W'(i)],
                                                      entry_count));
            end
            r = commit_word(ACT_CLEAR, '0, log_base, '0);
            r.last = 1'b1;
            pending_responses.push_back(r);
            entry_count = '0;
          end else begin
            pending_responses.push_back(status_word(ST_ENDED));
          end
        end
      end
      CMD_WRITE: begin
        hit = 1'b0;
        for (int i = 0; i < int'(entry_count); i++)
          if (journal[COUNT_W'(i)] == w.block_number) hit = 1'b1;
        if (hit) begin
          pending_responses.push_back(status_word(ST_ABSORBED));
        end else if (int'(entry_count) >= LOG_ENTRIES) begin
          pending_responses.push_back(status_word(ST_TABLE_FULL));
        end else begin
          journal[entry_count] = w.block_number;
          entry_count = entry_count + 1'b1;
          pending_responses.push_back(status_word(ST_ADDED));
        end
      end
      default: ;
    endcase
  endfunction

  // Receiver stalls in random bursts, only while idling is set
  always @(posedge clk) begin
    if (!idling) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      rsp_stall <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_word_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("response word with nothing expected");
      end else begin
        want = pending_responses.pop_front();
        check_field("status", 32'(rsp.status), 32'(want.status));
        check_field("action", 32'(rsp.action), 32'(want.action));
        check_field("source_block", 32'(rsp.source_block), 32'(want.source_block));
        check_field("dest_block", 32'(rsp.dest_block), 32'(want.dest_block));
        check_field("header_count", 32'(rsp.header_count), 32'(want.header_count));
        check_field("last", 32'(rsp.last), 32'(want.last));
        words_checked++;
        if (want.action == ACT_CLEAR) commits_seen++;
      end
    end
  end

  // Valid is left high after acceptance; the next word or a gap follows in the same step
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BLOCK_W-1:0] blk);
    req_word_t w;
    w.command = cmd;
    w.block_number = blk;
    if (idling && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (req_stall);
    predict_journal(w);
    items_sent++;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_log_start(input logic [BLOCK_W-1:0] value);
    logic [31:0] readback;
    wait_idle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= LOG_START_ADDR;
    pwdata <= {12'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    log_base = value;
    cfg_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (readback !== 32'(log_base))
      report_mismatch($sformatf("log_start_block read %0h, want %0h", readback, log_base));
  endtask

  task automatic test_directed_cases();
    idling = 1'b0;
    send_item(CMD_END, BLOCK_MAX);      // end with nothing open
    send_item(CMD_WRITE, '0);           // write outside an operation
    send_item(CMD_WRITE, '0);           // absorbed
    send_item(CMD_BEGIN, '0);
    send_item(CMD_BEGIN, BLOCK_MAX);
    send_item(CMD_BEGIN, '0);           // reserve does not fit: wait
    send_item(CMD_WRITE, BLOCK_MAX);
    send_item(CMD_WRITE, 20'h5a5a5);
    send_item(CMD_NONE, 20'ha5a5a);     // ignored
    send_item(CMD_END, '0);
    send_item(CMD_END, '0);             // commit, slots wrap past the top block
    send_item(CMD_BEGIN, '0);
    send_item(CMD_END, '0);             // last end with empty table
    send_item(CMD_BEGIN, '0);
    send_item(CMD_BEGIN, '0);
    send_item(CMD_BEGIN, '0);           // exactly fills the reserve
    send_item(CMD_BEGIN, '0);           // wait
    send_item(CMD_END, '0);
    send_item(CMD_END, '0);
    send_item(CMD_END, '0);
  endtask

  task automatic test_full_table();
    logic [BLOCK_W-1:0] blk;
    while (open_ops != 0) send_item(CMD_END, BLOCK_W'($urandom));
    send_item(CMD_BEGIN, BLOCK_W'($urandom));
    while (int'(entry_count) < LOG_ENTRIES) begin
      if (entry_count != 0 && $urandom_range(0, 4) == 0)
        blk = journal[COUNT_W'($urandom_range(0, int'(entry_count) - 1))];
      else
        blk = BLOCK_W'($urandom);
      send_item(CMD_WRITE, blk);
    end
    send_item(CMD_WRITE, BLOCK_W'($urandom));    // new block into a full table
    send_item(CMD_WRITE, journal[COUNT_W'(LOG_ENTRIES - 1)]);
    send_item(CMD_BEGIN, BLOCK_W'($urandom));
    send_item(CMD_END, BLOCK_W'($urandom));      // commit of the whole table
  endtask

  task automatic test_random_traffic(input int count, input bit allow_idle);
    logic [CMD_W-1:0] cmd;
    logic [BLOCK_W-1:0] blk;
    int roll;
    for (int n = 0; n < count; n++) begin
      if (n % 20 == 0) idling = allow_idle && ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 99);
      if (roll < 4)
        cmd = CMD_NONE;
      else if (open_ops == 0)
        cmd = (roll < 80) ? CMD_BEGIN : ((roll < 90) ? CMD_END : CMD_WRITE);
      else if (roll < 20)
        cmd = CMD_BEGIN;
      else if (roll < 42)
        cmd = CMD_END;
      else
        cmd = CMD_WRITE;
      // re-logging a block already in the table gives absorbs
      if (entry_count != 0 && $urandom_range(0, 2) == 0)
        blk = journal[COUNT_W'($urandom_range(0, int'(entry_count) - 1))];
      else
        blk = BLOCK_W'($urandom);
      send_item(cmd, blk);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_log_start(BLOCK_MAX);
    test_directed_cases();
    test_log_start(BLOCK_W'($urandom));
    test_random_traffic(50, 1'b1);
    test_full_table();
    test_log_start('0);
    idling = 1'b1;
    test_full_table();
    test_log_start(BLOCK_W'($urandom));
    test_random_traffic(70, 1'b1);
    test_log_start(BLOCK_W'($urandom));
    test_random_traffic(40, 1'b0);
    wait_idle();
    $display("Sent %0d request words; checked %0d response words over %0d commits.",
             items_sent, words_checked, commits_seen);
    $display("Log start block written %0d times, both ends of its range included.", cfg_writes);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
